// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the grid ray caster RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grid_ray_caster: check failed");
`define GRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("grid_ray_caster: check failed during reset");
`else
`define GRC_ASSERT(lbl, prop)
`define GRC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/grc_pkg.sv =====
// Shared constants, types and register codes for the grid ray caster.
// No dependencies; used by every module of the block.
`default_nettype none
package grc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAP_BITS   = 6;
  localparam int MAP_SIDE   = 1 << MAP_BITS;
  localparam int MAP_DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W     = 2 * MAP_BITS;
  localparam int TILE_W     = 4;
  localparam int MAX_STEPS  = 128;
  localparam int STEP_W     = $clog2(MAX_STEPS);

  localparam int COORD_W    = 22;
  localparam int DIR_W      = 19;
  localparam int SCR_W      = 13;
  localparam int FOCAL_W    = 18;
  localparam int VIEW_W     = 18;
  localparam int SIZE_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // internal datapath widths
  localparam int POS_W      = 25;
  localparam int DIFF_W     = FRAC_BITS + 2;
  localparam int NUM_W      = DIFF_W + DIR_W;
  localparam int CAND_W     = 40;
  localparam int DIV_NW     = 48;
  localparam int DIV_DW     = 28;
  localparam int DIV_CW     = $clog2(DIV_NW);
  localparam int DIST_W     = DIV_DW - 1;
  localparam int FW_W       = FOCAL_W + SCR_W;
  localparam int PROJ_W     = POS_W + 1 + VIEW_W;

  localparam int NUDGE      = ((1 << FRAC_BITS) + 50) / 100;
  localparam int CORNER_EPS = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int NORMAL_MIN = ((1 << FRAC_BITS) + 50) / 100;
  localparam int EPS_W      = $clog2(CORNER_EPS + 1);
  localparam int NPROD_W    = DIR_W + 11;
  localparam int NUDGE_W    = NPROD_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SIN      = 3'd4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [SCR_W-1:0]          screen_width;
    logic [SCR_W-1:0]          screen_height;
    logic [FOCAL_W-1:0]        focal_length;
    logic signed [VIEW_W-1:0]  view_cos;
    logic signed [VIEW_W-1:0]  view_sin;
  } grc_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [TILE_W-1:0]    hit_tile;
    logic [COORD_W-1:0]   hit_x;
    logic [COORD_W-1:0]   hit_y;
    logic [SCR_W-1:0]     wall_top;
    logic [SCR_W-1:0]     wall_bottom;
    logic [SIZE_W-1:0]    wall_size;
    logic                 no_hit;
  } grc_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grc_map_ram.sv =====
// Wall tile map: single write port, single read port, read data registered and valid the cycle after raddr.
// Depends on grc_pkg.
`default_nettype none
module grc_map_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [grc_pkg::ADDR_W-1:0] waddr,
  input  logic [grc_pkg::TILE_W-1:0] wdata,
  input  logic [grc_pkg::ADDR_W-1:0] raddr,
  output logic [grc_pkg::TILE_W-1:0] rdata
);

  logic [grc_pkg::TILE_W-1:0] mem_r [grc_pkg::MAP_DEPTH];
  logic [grc_pkg::TILE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/grc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on grc_pkg.
`default_nettype none
module grc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [grc_pkg::DIV_NW-1:0] dividend,
  input  logic [grc_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [grc_pkg::DIV_NW-1:0] quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [grc_pkg::DIV_CW-1:0] cnt_r;
  logic [grc_pkg::DIV_DW-1:0] rem_r;
  logic [grc_pkg::DIV_DW-1:0] den_r;
  logic [grc_pkg::DIV_NW-1:0] quo_r;

  logic [grc_pkg::DIV_DW:0]   shift_c;
  logic                       ge_c;
  logic [grc_pkg::DIV_DW:0]   diff_c;
  logic [grc_pkg::DIV_DW-1:0] rem_nxt;

  always_comb begin
    shift_c = {rem_r, quo_r[grc_pkg::DIV_NW-1]};
    ge_c    = shift_c >= {1'b0, den_r};
    diff_c  = shift_c - {1'b0, den_r};
    rem_nxt = ge_c ? diff_c[grc_pkg::DIV_DW-1:0] : shift_c[grc_pkg::DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == grc_pkg::DIV_CW'(grc_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[grc_pkg::DIV_NW-2:0], ge_c};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/grc_walker.sv =====
// Cast sequencer: grid stepping, map lookups and wall projection for one ray.
// Depends on grc_pkg and grc_div; reads the tile map through an external RAM port.
`default_nettype none
module grc_walker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [grc_pkg::COORD_W-1:0]        origin_x,
  input  logic [grc_pkg::COORD_W-1:0]        origin_y,
  input  logic signed [grc_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [grc_pkg::DIR_W-1:0]   dir_y,
  input  grc_pkg::grc_cfg_t                  cfg,
  output logic [grc_pkg::ADDR_W-1:0]         rd_addr,
  input  logic [grc_pkg::TILE_W-1:0]         rd_tile,
  input  logic                               res_ready,
  output logic                               busy,
  output grc_pkg::grc_res_t                  res
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SETUP = 5'd1;
  localparam logic [4:0] ST_LINE  = 5'd2;
  localparam logic [4:0] ST_MUL   = 5'd3;
  localparam logic [4:0] ST_DIVH  = 5'd4;
  localparam logic [4:0] ST_WTH   = 5'd5;
  localparam logic [4:0] ST_DIVV  = 5'd6;
  localparam logic [4:0] ST_WTV   = 5'd7;
  localparam logic [4:0] ST_SEL   = 5'd8;
  localparam logic [4:0] ST_RD    = 5'd9;
  localparam logic [4:0] ST_CHK   = 5'd10;
  localparam logic [4:0] ST_PM1   = 5'd11;
  localparam logic [4:0] ST_PM2   = 5'd12;
  localparam logic [4:0] ST_PSUM  = 5'd13;
  localparam logic [4:0] ST_PDIV  = 5'd14;
  localparam logic [4:0] ST_PWT   = 5'd15;
  localparam logic [4:0] ST_PEND  = 5'd16;
  localparam logic [4:0] ST_DONE  = 5'd17;

  localparam int F  = grc_pkg::FRAC_BITS;
  localparam int PW = grc_pkg::POS_W;
  localparam int CW = grc_pkg::CAND_W;
  localparam int NW = grc_pkg::NUM_W;
  localparam int MB = grc_pkg::MAP_BITS;

  localparam grc_pkg::pos_t ONE_P   = PW'(64'd1 << F);
  localparam grc_pkg::pos_t FRAC_MK = PW'((64'd1 << F) - 64'd1);
  localparam logic signed [grc_pkg::NPROD_W-1:0] NUDGE_V = grc_pkg::NPROD_W'(grc_pkg::NUDGE);
  localparam logic signed [grc_pkg::NPROD_W-1:0] NRND_V  =
    grc_pkg::NPROD_W'((64'd1 << F) - 64'd1);
  localparam logic [grc_pkg::EPS_W-1:0]   EPS_V    = grc_pkg::EPS_W'(grc_pkg::CORNER_EPS);
  localparam logic [2*grc_pkg::EPS_W:0]   EPS_SQ_V =
    (2*grc_pkg::EPS_W+1)'(grc_pkg::CORNER_EPS * grc_pkg::CORNER_EPS);
  localparam logic [grc_pkg::DIST_W-1:0]  DMIN_V   = grc_pkg::DIST_W'(grc_pkg::NORMAL_MIN);

  logic [4:0] state_r;

  grc_pkg::pos_t ox_r, oy_r, px_r, py_r, hx_r, vy_r;
  logic signed [grc_pkg::DIR_W-1:0]   dx_r, dy_r;
  logic signed [grc_pkg::NUDGE_W-1:0] nx_r, ny_r;
  logic signed [grc_pkg::DIFF_W-1:0]  hdx_r, vdy_r;
  logic signed [NW-1:0]               numh_r, numv_r;
  logic signed [CW-1:0]               hy_r, vx_r;
  logic                               div_neg_r;
  logic [grc_pkg::STEP_W-1:0]         step_r;
  logic                               hit_r;
  logic [grc_pkg::TILE_W-1:0]         tile_r;
  logic [grc_pkg::ADDR_W-1:0]         rd_addr_r;
  logic signed [grc_pkg::PROJ_W-1:0]  m1_r, m2_r;
  logic [grc_pkg::DIST_W-1:0]         dist_r;
  logic [grc_pkg::FW_W-1:0]           fw_r;
  logic [grc_pkg::DIV_NW-1:0]         size_r;
  logic [grc_pkg::SCR_W-1:0]          top_r, bot_r;
  logic [grc_pkg::SIZE_W-1:0]         whole_r;

  logic dx_nz, dy_nz;
  logic signed [grc_pkg::NPROD_W-1:0] pnx_c, pny_c;
  grc_pkg::pos_t hx_c, vy_c, hdx_c, vdy_c;
  logic [NW-1:0] numh_abs, numv_abs;
  logic                       div_start;
  logic [grc_pkg::DIV_NW-1:0] div_num;
  logic [grc_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;
  logic [grc_pkg::DIV_NW-1:0] div_q;
  logic signed [CW-1:0]       q_s;
  logic                       use_h, corner, rx_int, out_map;
  grc_pkg::pos_t              rx_c, ry_c, tx_c, ty_c;
  logic signed [CW-1:0]       ex_c, ey_c;
  logic [CW-1:0]              ex_a, ey_a;
  logic [2*grc_pkg::EPS_W:0]  sq_c;
  logic signed [PW:0]         rdx_c, rdy_c;
  logic signed [grc_pkg::PROJ_W:0] psum_c, padj_c, pdst_c;
  logic [grc_pkg::DIV_NW:0]   tsum_c, tq_c;
  logic signed [grc_pkg::DIV_NW+1:0] bdif_c, bq_c;

  always_comb begin
    dx_nz = dx_r != '0;
    dy_nz = dy_r != '0;

    pnx_c = grc_pkg::NPROD_W'(dx_r) * NUDGE_V;
    pny_c = grc_pkg::NPROD_W'(dy_r) * NUDGE_V;
    if (pnx_c[grc_pkg::NPROD_W-1]) pnx_c = pnx_c + NRND_V;
    if (pny_c[grc_pkg::NPROD_W-1]) pny_c = pny_c + NRND_V;

    // next grid line: floor(p)+1 going up, ceil(p)-1 going down
    hx_c  = dx_r[grc_pkg::DIR_W-1] ? ((px_r - PW'(1)) & ~FRAC_MK) : ((px_r + ONE_P) & ~FRAC_MK);
    vy_c  = dy_r[grc_pkg::DIR_W-1] ? ((py_r - PW'(1)) & ~FRAC_MK) : ((py_r + ONE_P) & ~FRAC_MK);
    hdx_c = hx_c - px_r;
    vdy_c = vy_c - py_r;

    numh_abs = numh_r[NW-1] ? NW'(-numh_r) : NW'(numh_r);
    numv_abs = numv_r[NW-1] ? NW'(-numv_r) : NW'(numv_r);

    case (state_r)
      ST_DIVV: begin
        div_num = grc_pkg::DIV_NW'(numv_abs);
        div_den = grc_pkg::DIV_DW'(dy_r[grc_pkg::DIR_W-1] ? -dy_r : dy_r);
      end
      ST_PDIV: begin
        div_num = grc_pkg::DIV_NW'({fw_r, F'(0)});
        div_den = grc_pkg::DIV_DW'({dist_r, 1'b0});
      end
      default: begin
        div_num = grc_pkg::DIV_NW'(numh_abs);
        div_den = grc_pkg::DIV_DW'(dx_r[grc_pkg::DIR_W-1] ? -dx_r : dx_r);
      end
    endcase
    div_start = (state_r == ST_DIVH && dx_nz) || (state_r == ST_DIVV && dy_nz) ||
                (state_r == ST_PDIV);

    q_s = div_neg_r ? -$signed(div_q[CW-1:0]) : $signed(div_q[CW-1:0]);

    use_h = dx_nz && (!dy_nz || numh_abs < numv_abs);
    rx_c  = use_h ? hx_r : vx_r[PW-1:0];
    ry_c  = use_h ? hy_r[PW-1:0] : vy_r;
    ex_c  = CW'(hx_r) - vx_r;
    ey_c  = hy_r - CW'(vy_r);
    ex_a  = ex_c[CW-1] ? CW'(-ex_c) : CW'(ex_c);
    ey_a  = ey_c[CW-1] ? CW'(-ey_c) : CW'(ey_c);
    sq_c  = (2*grc_pkg::EPS_W+1)'(ex_a[grc_pkg::EPS_W-1:0] * ex_a[grc_pkg::EPS_W-1:0]) +
            (2*grc_pkg::EPS_W+1)'(ey_a[grc_pkg::EPS_W-1:0] * ey_a[grc_pkg::EPS_W-1:0]);
    corner = dx_nz && dy_nz && ex_a < CW'(EPS_V) && ey_a < CW'(EPS_V) && sq_c < EPS_SQ_V;
    rx_int = rx_c[F-1:0] == '0;
    tx_c  = rx_c + ((corner || rx_int) ? PW'(nx_r) : '0);
    ty_c  = ry_c + ((corner || !rx_int) ? PW'(ny_r) : '0);
    out_map = tx_c[PW-1] || ty_c[PW-1] || (tx_c[PW-2:F+MB] != '0) || (ty_c[PW-2:F+MB] != '0);

    rdx_c  = (PW+1)'(px_r) - (PW+1)'(ox_r);
    rdy_c  = (PW+1)'(py_r) - (PW+1)'(oy_r);
    psum_c = (grc_pkg::PROJ_W+1)'(m1_r) + (grc_pkg::PROJ_W+1)'(m2_r);
    padj_c = psum_c[grc_pkg::PROJ_W] ? psum_c + (grc_pkg::PROJ_W+1)'(65535) : psum_c;
    pdst_c = padj_c >>> 16;

    tsum_c = (grc_pkg::DIV_NW+1)'({cfg.screen_height, 16'b0}) + (grc_pkg::DIV_NW+1)'(size_r);
    tq_c   = tsum_c >> 17;
    bdif_c = (grc_pkg::DIV_NW+2)'({cfg.screen_height, 16'b0}) -
             (grc_pkg::DIV_NW+2)'(size_r);
    bq_c   = bdif_c >>> 17;
  end

  grc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE:  if (start) state_r <= ST_SETUP;
        ST_SETUP: state_r <= (dx_nz || dy_nz) ? ST_LINE : ST_DONE;
        ST_LINE:  state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_DIVH;
        ST_DIVH:  state_r <= dx_nz ? ST_WTH : ST_DIVV;
        ST_WTH:   if (div_done) state_r <= ST_DIVV;
        ST_DIVV:  state_r <= dy_nz ? ST_WTV : ST_SEL;
        ST_WTV:   if (div_done) state_r <= ST_SEL;
        ST_SEL:   state_r <= out_map ? ST_DONE : ST_RD;
        ST_RD:    state_r <= ST_CHK;
        ST_CHK: begin
          if (rd_tile != '0) begin
            state_r <= ST_PM1;
          end else if (step_r == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_LINE;
          end
        end
        ST_PM1:   state_r <= ST_PM2;
        ST_PM2:   state_r <= ST_PSUM;
        ST_PSUM:  state_r <= ST_PDIV;
        ST_PDIV:  state_r <= ST_PWT;
        ST_PWT:   if (div_done) state_r <= ST_PEND;
        ST_PEND:  state_r <= ST_DONE;
        ST_DONE:  if (res_ready) state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ox_r <= PW'(origin_x);
        oy_r <= PW'(origin_y);
        dx_r <= dir_x;
        dy_r <= dir_y;
      end
      ST_SETUP: begin
        nx_r   <= grc_pkg::NUDGE_W'(pnx_c >>> F);
        ny_r   <= grc_pkg::NUDGE_W'(pny_c >>> F);
        px_r   <= ox_r;
        py_r   <= oy_r;
        step_r <= '0;
        hit_r  <= 1'b0;
      end
      ST_LINE: begin
        hx_r  <= hx_c;
        vy_r  <= vy_c;
        hdx_r <= hdx_c[grc_pkg::DIFF_W-1:0];
        vdy_r <= vdy_c[grc_pkg::DIFF_W-1:0];
      end
      ST_MUL: begin
        numh_r <= NW'(hdx_r) * NW'(dy_r);
        numv_r <= NW'(vdy_r) * NW'(dx_r);
      end
      ST_DIVH: div_neg_r <= numh_r[NW-1] ^ dx_r[grc_pkg::DIR_W-1];
      ST_WTH:  if (div_done) hy_r <= CW'(py_r) + q_s;
      ST_DIVV: div_neg_r <= numv_r[NW-1] ^ dy_r[grc_pkg::DIR_W-1];
      ST_WTV:  if (div_done) vx_r <= CW'(px_r) + q_s;
      ST_SEL: begin
        px_r      <= rx_c;
        py_r      <= ry_c;
        rd_addr_r <= {ty_c[F+MB-1:F], tx_c[F+MB-1:F]};
      end
      ST_CHK: begin
        step_r <= step_r + 1'b1;
        tile_r <= rd_tile;
        hit_r  <= rd_tile != '0;
      end
      ST_PM1: m1_r <= grc_pkg::PROJ_W'(rdx_c) * grc_pkg::PROJ_W'(cfg.view_cos);
      ST_PM2: m2_r <= grc_pkg::PROJ_W'(rdy_c) * grc_pkg::PROJ_W'(cfg.view_sin);
      ST_PSUM: begin
        dist_r <= (pdst_c < (grc_pkg::PROJ_W+1)'(grc_pkg::NORMAL_MIN)) ? DMIN_V
                                                   : pdst_c[grc_pkg::DIST_W-1:0];
        fw_r   <= grc_pkg::FW_W'(cfg.focal_length) * grc_pkg::FW_W'(cfg.screen_width);
      end
      ST_PWT: if (div_done) size_r <= div_q;
      ST_PEND: begin
        top_r   <= (tq_c > (grc_pkg::DIV_NW+1)'(cfg.screen_height)) ? cfg.screen_height
                                                                    : tq_c[grc_pkg::SCR_W-1:0];
        bot_r   <= bdif_c[grc_pkg::DIV_NW+1] ? '0 : bq_c[grc_pkg::SCR_W-1:0];
        whole_r <= (size_r[grc_pkg::DIV_NW-1:16+grc_pkg::SIZE_W] != '0) ? '1
                                           : size_r[16+grc_pkg::SIZE_W-1:16];
      end
      default: ;
    endcase
  end

  always_comb begin
    res.valid       = state_r == ST_DONE;
    res.no_hit      = !hit_r;
    res.hit_tile    = hit_r ? tile_r : '0;
    res.hit_x       = px_r[PW-1] ? '0 :
                      (px_r[PW-2:grc_pkg::COORD_W] != '0) ? '1 : px_r[grc_pkg::COORD_W-1:0];
    res.hit_y       = py_r[PW-1] ? '0 :
                      (py_r[PW-2:grc_pkg::COORD_W] != '0) ? '1 : py_r[grc_pkg::COORD_W-1:0];
    res.wall_top    = hit_r ? top_r : '0;
    res.wall_bottom = hit_r ? bot_r : '0;
    res.wall_size   = hit_r ? whole_r : '0;
  end

  assign busy    = state_r != ST_IDLE;
  assign rd_addr = rd_addr_r;

endmodule
`default_nettype wire

// ===== hw/rtl/grid_ray_caster.sv =====
// Top level: config registers, map clear sweep, input/output stream channels.
// Depends on grc_pkg, grc_map_ram, grc_walker and assert_macros.svh.
//
//  channel   dir  handshake              payload
//  in_*      in   in_tvalid/in_tready    tuser kind, tdata load or cast fields
//  out_*     out  out_tvalid/out_tready  tuser no_hit, tdata result fields
//  cfg_*     in   cfg_we                 cfg_addr register index, cfg_wdata
//
// A load writes its map cell on acceptance. A cast walks the grid step by step (a zero
// direction part skips the divide for that axis) and projects the wall on a hit; each divide
// holds the shared 48-bit serial divider, which sets the pace of a cast.
// After reset all 4096 map cells are swept to zero; in_tready stays low until the sweep ends.
// A finished result waits in the output register while the next request runs.
`default_nettype none
`include "assert_macros.svh"
module grid_ray_caster (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // kind
  input  logic                                 in_tuser,
  // cell_x, cell_y, cell_tile, origin_x, origin_y, dir_x, dir_y, zero pad
  input  logic [103:0]                         in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // no_hit
  output logic                                 out_tuser,
  // hit_tile, hit_x, hit_y, wall_top, wall_bottom, wall_size, zero pad
  output logic [95:0]                          out_tdata,
  input  logic                                 cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [grc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  grc_pkg::grc_cfg_t cfg_r;
  logic                        clr_busy_r;
  logic [grc_pkg::ADDR_W-1:0]  clr_addr_r;
  logic                        out_tvalid_r;
  logic                        out_tuser_r;
  logic [95:0]                 out_tdata_r;

  logic                        accept;
  logic                        load_we;
  logic                        ram_we;
  logic [grc_pkg::ADDR_W-1:0]  ram_waddr;
  logic [grc_pkg::TILE_W-1:0]  ram_wdata;
  logic [grc_pkg::ADDR_W-1:0]  ram_raddr;
  logic [grc_pkg::TILE_W-1:0]  ram_rdata;
  logic                        wk_busy;
  logic                        res_ready;
  grc_pkg::grc_res_t           wk_res;

  assign in_tready = !clr_busy_r && !wk_busy;
  assign accept    = in_tvalid && in_tready;
  assign load_we   = accept && (in_tuser == grc_pkg::KIND_LOAD);
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    ram_we    = clr_busy_r || load_we;
    ram_waddr = clr_busy_r ? clr_addr_r : {in_tdata[11:6], in_tdata[5:0]};
    ram_wdata = clr_busy_r ? '0 : in_tdata[15:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 13'd700;
      cfg_r.screen_height <= 13'd400;
      cfg_r.focal_length  <= 18'd52429;
      cfg_r.view_cos      <= 18'sd65536;
      cfg_r.view_sin      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        grc_pkg::CFG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[grc_pkg::SCR_W-1:0];
        grc_pkg::CFG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[grc_pkg::SCR_W-1:0];
        grc_pkg::CFG_FOCAL_LENGTH:  cfg_r.focal_length  <= cfg_wdata;
        grc_pkg::CFG_VIEW_COS:      cfg_r.view_cos      <= cfg_wdata;
        grc_pkg::CFG_VIEW_SIN:      cfg_r.view_sin      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) clr_busy_r <= 1'b0;
    end
  end

  grc_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grc_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && (in_tuser == grc_pkg::KIND_CAST)),
    .origin_x  (in_tdata[37:16]),
    .origin_y  (in_tdata[59:38]),
    .dir_x     (in_tdata[78:60]),
    .dir_y     (in_tdata[97:79]),
    .cfg       (cfg_r),
    .rd_addr   (ram_raddr),
    .rd_tile   (ram_rdata),
    .res_ready (res_ready),
    .busy      (wk_busy),
    .res       (wk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (wk_res.valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wk_res.valid && res_ready) begin
      out_tuser_r <= wk_res.no_hit;
      out_tdata_r <= {2'b00, wk_res.wall_size, wk_res.wall_bottom, wk_res.wall_top,
                      wk_res.hit_y, wk_res.hit_x, wk_res.hit_tile};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  `GRC_ASSERT(a_clear_idle, clr_busy_r |-> !wk_busy)
  `GRC_ASSERT(a_cast_starts, (accept && in_tuser == grc_pkg::KIND_CAST) |=> wk_busy)
  `GRC_ASSERT(a_miss_zero, (out_tvalid_r && out_tuser_r) |-> (out_tdata_r[3:0] == '0 && out_tdata_r[93:74] == '0))
  `GRC_ASSERT(a_hit_tile, (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r[3:0] != '0))
  `GRC_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (clr_busy_r && !wk_busy && !out_tvalid_r))

endmodule
`default_nettype wire
